@@ rtl/brws_pkg.sv @@
// brws_pkg: shared widths, constants and controller/datapath interface types
// for the banked row window splitter. No dependencies.
`timescale 1ns / 1ps

package brws_pkg;

   // Field widths
   localparam int ROW_W       = 11;
   localparam int COL_W       = 11;
   localparam int LEN_W       = 12;
   localparam int BANK_W      = 14;
   localparam int WOFF_W      = 16;
   localparam int SRC_W       = 22;
   localparam int PITCH_W     = 14;
   localparam int KB_W        = 7;
   localparam int SWIDTH_W    = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 64;

   // Display byte offset: row * pitch + column fits 25 bits
   localparam int OFS_W       = ROW_W + PITCH_W;
   localparam int KB_SHIFT    = 10;
   localparam int DIVIDEND_W  = OFS_W - KB_SHIFT;
   localparam int GRAN_W      = KB_W + KB_SHIFT;

   localparam int MAX_GRAN_KB = 64;
   localparam int MAX_CHUNKS  = 3;
   localparam int NCHUNK_W    = 2;
   localparam int MAX_ROW_PIXELS_DEF = 2048;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_GRAN_KB = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH = 2'd2;

   // Reset values
   localparam logic [PITCH_W-1:0]  PITCH_RST  = 14'd640;
   localparam logic [KB_W-1:0]     KB_RST     = 7'd64;
   localparam logic [SWIDTH_W-1:0] SWIDTH_RST = 12'd640;

   typedef struct packed {
      logic capture;     // latch request fields
      logic mul;         // form display and back-buffer offsets
      logic div_start;   // launch bank divide
      logic load_div;    // take quotient and remainder
      logic emit;        // load next chunk into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic rem_zero;    // nothing left to copy
      logic div_done;
      logic out_free;    // output register can take a chunk this cycle
      logic last;        // chunk being formed is the final one
   } dp_sts_type;

endpackage

@@ rtl/brws_div.sv @@
// brws_div: restoring divider, one quotient bit per cycle.
// Divides the display offset in KB by the bank granularity. Uses brws_pkg.
`timescale 1ns / 1ps

module brws_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [brws_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [brws_pkg::KB_W-1:0]       divisor,
   output logic                            done,
   output logic [brws_pkg::DIVIDEND_W-1:0] quotient,
   output logic [brws_pkg::KB_W-1:0]       remainder
);
   import brws_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [KB_W-1:0]       rem_ff, rem_in;
   logic [KB_W-1:0]       div_ff, div_in;
   logic [KB_W:0]         trial;
   logic [KB_W:0]         diff;
   logic                  qbit;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, div_ff};
      qbit    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], qbit};
         rem_in = qbit ? diff[KB_W-1:0] : trial[KB_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

endmodule

@@ rtl/brws_dpath.sv @@
// brws_dpath: config registers, request registers, offset multipliers,
// chunk arithmetic and output register. Uses brws_pkg and brws_div.
`timescale 1ns / 1ps

module brws_dpath #(
   parameter int MAX_ROW_PIXELS = brws_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [brws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brws_pkg::PITCH_W-1:0]    csr_wdata,
   input  logic [brws_pkg::REQ_DATA_W-1:0] req_tdata,
   input  brws_pkg::dp_cmd_type            cmd,
   output brws_pkg::dp_sts_type            sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [brws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import brws_pkg::*;

   // Config
   logic [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic [KB_W-1:0]     kb_ff, kb_in;
   logic [SWIDTH_W-1:0] swidth_ff, swidth_in;
   logic [KB_W-1:0]     kb_wr;

   // Request and working state
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [OFS_W-1:0]    ofs_ff, ofs_in;
   logic [SRC_W-1:0]    src_ff, src_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [WOFF_W-1:0]   boff_ff, boff_in;
   logic [NCHUNK_W-1:0] nchunk_ff, nchunk_in;

   // Output register
   logic                out_valid_ff, out_valid_in;
   logic [BANK_W-1:0]   out_bank_ff, out_bank_in;
   logic [WOFF_W-1:0]   out_woff_ff, out_woff_in;
   logic [LEN_W-1:0]    out_len_ff, out_len_in;
   logic [SRC_W-1:0]    out_src_ff, out_src_in;
   logic                out_last_ff, out_last_in;

   logic [ROW_W-1:0]    req_row;
   logic [COL_W-1:0]    req_col;
   logic [LEN_W-1:0]    req_len;
   logic [OFS_W-1:0]    disp_prod;
   logic [ROW_W+SWIDTH_W-1:0] src_prod;
   logic [GRAN_W-1:0]   gran;
   logic [GRAN_W-1:0]   avail;
   logic [LEN_W-1:0]    chunk;
   logic [LEN_W-1:0]    rem_next;
   logic                last;
   logic                out_free;

   logic                      div_done;
   logic [DIVIDEND_W-1:0]     div_quo;
   logic [KB_W-1:0]           div_rem;

   assign req_row = req_tdata[ROW_W-1:0];
   assign req_col = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_len = req_tdata[ROW_W+COL_W+LEN_W-1:ROW_W+COL_W];

   assign kb_wr = csr_wdata[KB_W-1:0];

   always_comb begin
      pitch_in  = pitch_ff;
      kb_in     = kb_ff;
      swidth_in = swidth_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LINE_PITCH:   pitch_in  = csr_wdata;
            // zero or above range both mean the largest window
            CSR_BANK_GRAN_KB: kb_in = (kb_wr == '0 || kb_wr > KB_W'(MAX_GRAN_KB)) ?
                                      KB_W'(MAX_GRAN_KB) : kb_wr;
            CSR_SCREEN_WIDTH: swidth_in = csr_wdata[SWIDTH_W-1:0];
            default:          pitch_in  = pitch_ff;
         endcase
      end
   end

   brws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (ofs_ff[OFS_W-1:KB_SHIFT]),
      .divisor   (kb_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      disp_prod = OFS_W'(row_ff) * OFS_W'(pitch_ff);
      src_prod  = row_ff * swidth_ff;
      gran      = {kb_ff, {KB_SHIFT{1'b0}}};
      avail     = gran - GRAN_W'(boff_ff);
      chunk     = (GRAN_W'(rem_ff) < avail) ? rem_ff : avail[LEN_W-1:0];
      rem_next  = rem_ff - chunk;
      last      = (rem_next == '0) || (nchunk_ff == NCHUNK_W'(MAX_CHUNKS - 1));
      out_free  = !out_valid_ff || rsp_tready;

      row_in    = row_ff;
      col_in    = col_ff;
      rem_in    = rem_ff;
      ofs_in    = ofs_ff;
      src_in    = src_ff;
      bank_in   = bank_ff;
      boff_in   = boff_ff;
      nchunk_in = nchunk_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_bank_in  = out_bank_ff;
      out_woff_in  = out_woff_ff;
      out_len_in   = out_len_ff;
      out_src_in   = out_src_ff;
      out_last_in  = out_last_ff;

      if (cmd.capture) begin
         row_in    = req_row;
         col_in    = req_col;
         rem_in    = ({1'b0, req_len} > (LEN_W+1)'(MAX_ROW_PIXELS)) ?
                     LEN_W'(MAX_ROW_PIXELS) : req_len;
         nchunk_in = '0;
      end
      if (cmd.mul) begin
         ofs_in = disp_prod + OFS_W'(col_ff);
         src_in = SRC_W'(src_prod) + SRC_W'(col_ff);
      end
      if (cmd.load_div) begin
         bank_in = div_quo[BANK_W-1:0];
         boff_in = {div_rem[WOFF_W-KB_SHIFT-1:0], ofs_ff[KB_SHIFT-1:0]};
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_bank_in  = bank_ff;
         out_woff_in  = boff_ff;
         out_len_in   = chunk;
         out_src_in   = src_ff;
         out_last_in  = last;
         // next chunk starts at the base of the following window
         rem_in       = rem_next;
         bank_in      = bank_ff + 1'b1;
         boff_in      = '0;
         src_in       = src_ff + SRC_W'(chunk);
         nchunk_in    = nchunk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff     <= PITCH_RST;
         kb_ff        <= KB_RST;
         swidth_ff    <= SWIDTH_RST;
         out_valid_ff <= 1'b0;
         nchunk_ff    <= '0;
      end else begin
         pitch_ff     <= pitch_in;
         kb_ff        <= kb_in;
         swidth_ff    <= swidth_in;
         out_valid_ff <= out_valid_in;
         nchunk_ff    <= nchunk_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      rem_ff      <= rem_in;
      ofs_ff      <= ofs_in;
      src_ff      <= src_in;
      bank_ff     <= bank_in;
      boff_ff     <= boff_in;
      out_bank_ff <= out_bank_in;
      out_woff_ff <= out_woff_in;
      out_len_ff  <= out_len_in;
      out_src_ff  <= out_src_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.rem_zero = (rem_ff == '0);
      sts.div_done = div_done;
      sts.out_free = out_free;
      sts.last     = last;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_src_ff, out_len_ff, out_woff_ff, out_bank_ff};
   assign rsp_tlast  = out_last_ff;

   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("chunk loaded over an untaken result");

   a_chunk_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (chunk != '0))
      else $error("empty chunk emitted");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> out_valid_ff)
      else $error("emitted chunk not presented");

endmodule

@@ rtl/brws_ctrl.sv @@
// brws_ctrl: sequencer for one request: capture, multiply, then, for a nonzero
// length, divide and one chunk per free output slot. Uses brws_pkg command/status types.
`timescale 1ns / 1ps

module brws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  brws_pkg::dp_sts_type sts,
   output brws_pkg::dp_cmd_type cmd
);
   import brws_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL      = 3'd1;
   localparam logic [2:0] ST_DIV_GO   = 3'd2;
   localparam logic [2:0] ST_DIV_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.rem_zero ? ST_IDLE : ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.load_div = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/banked_row_window_splitter_top.sv @@
// banked_row_window_splitter_top: splits a row copy request into chunks that
// each stay inside one bank window. Uses brws_pkg, brws_ctrl, brws_dpath.
//
//   port group  dir  fields
//   req_*       in   tdata: row_index, start_column, row_length
//   rsp_*       out  tdata: bank_number, window_offset, chunk_length,
//                    source_offset; tlast: last_chunk
//   csr_*       in   index 0 line_pitch, 1 bank_granularity_kb, 2 screen_width
//
// A request with a nonzero length goes through capture, multiply, divide launch,
// 15 divide steps and a load, then one chunk per free output slot (up to 3 chunks).
// Reset is synchronous, active high; config registers return to 640/64/640.
// rsp_tready low holds the chunk in the output register; the next request is
// taken once the final chunk is in that register.
`timescale 1ns / 1ps

module banked_row_window_splitter_top #(
   parameter int MAX_ROW_PIXELS = brws_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [brws_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brws_pkg::PITCH_W-1:0]    csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // row_index[10:0], start_column[21:11], row_length[33:22], zero fill
   input  logic [brws_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // bank_number[13:0], window_offset[29:14], chunk_length[41:30],
   // source_offset[63:42]
   output logic [brws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import brws_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   brws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   brws_dpath #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
